// ----- rtl/tet_pkg.sv -----
// ============================================================================
// tet_pkg: shared constants and helpers for the screw-axis exponential
// CORDIC angle table, fixed-point constants, rounding and saturation helpers.
// ============================================================================
`default_nettype none
package tet_pkg;
    localparam int CORDIC_STEPS_DEF = 18;
    localparam int CW = 34;  // CORDIC datapath width (Q30 with headroom)
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic [31:0] t;
        begin
            unique case (i)
                0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
                3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
                6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
                9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
                12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
                15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
                18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
                21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
                24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
                27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
                30: t = 32'h00000001;
                default: t = 32'h00000000;
            endcase
            atan_q30 = $signed({2'b00, t});
        end
    endfunction

    // Operands carried alongside the CORDIC cells.
    typedef struct packed {
        logic signed [17:0] wx;
        logic signed [17:0] wy;
        logic signed [17:0] wz;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic signed [19:0] vz;
        logic signed [18:0] th;
    } axis_t;

    // Round half up by 32 bits and saturate to an 18-bit result.
    function automatic logic signed [17:0] rsat18(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + 64'sd2147483648) >>> 32;
            if (r > 64'sd131071) rsat18 = 18'sd131071;
            else if (r < -64'sd131072) rsat18 = -18'sd131072;
            else rsat18 = r[17:0];
        end
    endfunction

    function automatic logic signed [23:0] rsat24(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + 64'sd2147483648) >>> 32;
            if (r > 64'sd8388607) rsat24 = 24'sd8388607;
            else if (r < -64'sd8388608) rsat24 = -24'sd8388608;
            else rsat24 = r[23:0];
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/tet_cordic_cell.sv -----
// ============================================================================
// tet_cordic_cell: one CORDIC rotation step
// Registers x, y, z and the carried item for the next cell in the chain.
// ============================================================================
`default_nettype none
module tet_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire  logic                              aclk,
    input  wire  logic                              aresetn,
    input  wire  logic                              en,
    input  wire  logic                              vld_in,
    input  wire  logic signed [tet_pkg::CW-1:0]     x_in,
    input  wire  logic signed [tet_pkg::CW-1:0]     y_in,
    input  wire  logic signed [tet_pkg::CW-1:0]     z_in,
    input  wire  logic                              flip_in,
    input  wire  tet_pkg::axis_t                    ax_in,
    output logic                                    vld_out,
    output logic signed [tet_pkg::CW-1:0]           x_out,
    output logic signed [tet_pkg::CW-1:0]           y_out,
    output logic signed [tet_pkg::CW-1:0]           z_out,
    output logic                                    flip_out,
    output tet_pkg::axis_t                          ax_out
);
    logic signed [tet_pkg::CW-1:0] xs, ys, x_next, y_next, z_next;
    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;
    always_comb begin
        if (!z_in[tet_pkg::CW-1]) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - tet_pkg::atan_q30(STEP);
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + tet_pkg::atan_q30(STEP);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out <= 1'b0;
        end else if (en) begin
            vld_out <= vld_in;
        end
        if (en) begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            flip_out <= flip_in;
            ax_out   <= ax_in;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tet_post.sv -----
// ============================================================================
// tet_post: matrix tail of the transform
// Four register stages from sine/cosine and the axis to R and p.
// ============================================================================
`default_nettype none
module tet_post (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    input  wire  logic                          en,
    input  wire  logic                          vld_in,
    input  wire  logic signed [tet_pkg::CW-1:0] x_in,
    input  wire  logic signed [tet_pkg::CW-1:0] y_in,
    input  wire  logic                          flip_in,
    input  wire  tet_pkg::axis_t                ax_in,
    output logic                                vld_out,
    output logic signed [17:0]                  r_out [9],
    output logic signed [23:0]                  p_out [3]
);
    localparam int CW_S = tet_pkg::CW;

    // stage 1: sin/cos, skew products W2 and u
    logic                 v1_reg;
    logic signed [18:0]   s1_reg, a1_reg;
    logic signed [20:0]   b1_reg;
    logic signed [18:0]   w1_reg [9];
    logic signed [19:0]   vv1_reg [3];
    logic signed [18:0]   th1_reg;
    logic signed [37:0]   w2_reg [9];
    logic signed [40:0]   u_reg [3];
    // stage 2: u2
    logic                 v2_reg;
    logic signed [18:0]   s2_reg, a2_reg;
    logic signed [20:0]   b2_reg;
    logic signed [18:0]   w2m_reg [9];
    logic signed [19:0]   vv2_reg [3];
    logic signed [18:0]   th2_reg;
    logic signed [37:0]   ww2_reg [9];
    logic signed [40:0]   u2u_reg [3];
    logic signed [43:0]   u2_reg [3];
    // stage 3: products
    logic                 v3_reg;
    logic signed [63:0]   rt_reg [9];
    logic signed [63:0]   pt_reg [3];

    logic signed [CW_S-1:0] sx, cx;
    logic signed [CW_S-1:0] xf, yf;
    // skew entries need one extra bit: negating the most negative input
    logic signed [18:0] wm [9];
    logic signed [18:0] s16, c16;
    logic signed [63:0] acc2 [3];

    assign xf = flip_in ? -x_in : x_in;
    assign yf = flip_in ? -y_in : y_in;
    assign sx = (yf + 34'sd8192) >>> 14;
    assign cx = (xf + 34'sd8192) >>> 14;
    assign s16 = sx[18:0];
    assign c16 = cx[18:0];
    always_comb begin
        wm[0] = '0;
        wm[1] = -19'(ax_in.wz);
        wm[2] = 19'(ax_in.wy);
        wm[3] = 19'(ax_in.wz);
        wm[4] = '0;
        wm[5] = -19'(ax_in.wx);
        wm[6] = -19'(ax_in.wy);
        wm[7] = 19'(ax_in.wx);
        wm[8] = '0;
    end
    // W u from the stage-1 registers, so u2 lines up with stage 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc2[i] = 64'(w1_reg[3*i]) * 64'(u_reg[0])
                    + 64'(w1_reg[3*i+1]) * 64'(u_reg[1])
                    + 64'(w1_reg[3*i+2]) * 64'(u_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; vld_out <= 1'b0;
        end else if (en) begin
            v1_reg <= vld_in; v2_reg <= v1_reg; v3_reg <= v2_reg; vld_out <= v3_reg;
        end
        if (en) begin
            s1_reg  <= s16;
            a1_reg  <= 19'sd65536 - c16;
            b1_reg  <= 21'(ax_in.th) - 21'(s16);
            th1_reg <= ax_in.th;
            vv1_reg[0] <= ax_in.vx; vv1_reg[1] <= ax_in.vy; vv1_reg[2] <= ax_in.vz;
            for (int i = 0; i < 9; i++) w1_reg[i] <= wm[i];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    w2_reg[3*i+j] <= 38'(wm[3*i]) * 38'(wm[j])
                                   + 38'(wm[3*i+1]) * 38'(wm[3+j])
                                   + 38'(wm[3*i+2]) * 38'(wm[6+j]);
                end
                u_reg[i] <= 41'(wm[3*i]) * 41'(ax_in.vx)
                          + 41'(wm[3*i+1]) * 41'(ax_in.vy)
                          + 41'(wm[3*i+2]) * 41'(ax_in.vz);
            end
            // stage 2
            s2_reg <= s1_reg; a2_reg <= a1_reg; b2_reg <= b1_reg; th2_reg <= th1_reg;
            for (int i = 0; i < 9; i++) begin
                w2m_reg[i] <= w1_reg[i];
                ww2_reg[i] <= w2_reg[i];
            end
            for (int i = 0; i < 3; i++) begin
                vv2_reg[i] <= vv1_reg[i];
                u2u_reg[i] <= u_reg[i];
            end
            for (int i = 0; i < 3; i++) u2_reg[i] <= 44'((acc2[i] + 64'sd32768) >>> 16);
            // stage 3: final accumulations in Q48
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rt_reg[3*i+j] <= ((i == j) ? (64'sd1 <<< 48) : 64'sd0)
                        + ((64'(s2_reg) * 64'(w2m_reg[3*i+j])) <<< 16)
                        + 64'(a2_reg) * 64'(ww2_reg[3*i+j]);
                end
                pt_reg[i] <= ((64'(th2_reg) * 64'(vv2_reg[i])) <<< 16)
                           + 64'(a2_reg) * 64'(u2u_reg[i])
                           + 64'(b2_reg) * 64'(u2_reg[i]);
            end
            // stage 4: round and saturate
            for (int i = 0; i < 9; i++) r_out[i] <= tet_pkg::rsat18(rt_reg[i]);
            for (int i = 0; i < 3; i++) p_out[i] <= tet_pkg::rsat24(pt_reg[i]);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/twist_exponential_transform_top.sv -----
// ============================================================================
// twist_exponential_transform_top: screw-axis exponential exp([S] theta)
// Pipeline: 1 range-reduction stage, CORDIC_STEPS cells and 4 tail stages.
// Throughput: one transfer per cycle; the pipeline stalls as a whole on m_ready.
// Reset: synchronous active-low aresetn clears all valid flags; data untouched.
// ============================================================================
`default_nettype none
module twist_exponential_transform_top #(
    parameter int CORDIC_STEPS = tet_pkg::CORDIC_STEPS_DEF
) (
    input  wire  logic               aclk,
    input  wire  logic               aresetn,
    input  wire  logic               s_valid,
    output logic                     s_ready,
    input  wire  logic signed [17:0] s_omega_x,
    input  wire  logic signed [17:0] s_omega_y,
    input  wire  logic signed [17:0] s_omega_z,
    input  wire  logic signed [19:0] s_lin_x,
    input  wire  logic signed [19:0] s_lin_y,
    input  wire  logic signed [19:0] s_lin_z,
    input  wire  logic signed [18:0] s_angle,
    output logic                     m_valid,
    input  wire  logic               m_ready,
    output logic signed [17:0]       m_r00,
    output logic signed [17:0]       m_r01,
    output logic signed [17:0]       m_r02,
    output logic signed [17:0]       m_r10,
    output logic signed [17:0]       m_r11,
    output logic signed [17:0]       m_r12,
    output logic signed [17:0]       m_r20,
    output logic signed [17:0]       m_r21,
    output logic signed [17:0]       m_r22,
    output logic signed [23:0]       m_p_x,
    output logic signed [23:0]       m_p_y,
    output logic signed [23:0]       m_p_z
);
    localparam int CW = tet_pkg::CW;
    localparam int NC = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    // The whole pipe advances when the output register is empty or drained.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Range-reduction stage: theta to Q30, fold into [-pi/2, pi/2].
    logic                   v0_reg, f0_reg;
    logic signed [CW-1:0]   z0_reg;
    tet_pkg::axis_t         a0_reg;
    logic signed [CW-1:0]   zq;
    assign zq = CW'(s_angle) <<< 14;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
        if (en) begin
            if (zq > tet_pkg::HALF_PI_Q30) begin
                z0_reg <= zq - tet_pkg::PI_Q30; f0_reg <= 1'b1;
            end else if (zq < -tet_pkg::HALF_PI_Q30) begin
                z0_reg <= zq + tet_pkg::PI_Q30; f0_reg <= 1'b1;
            end else begin
                z0_reg <= zq; f0_reg <= 1'b0;
            end
            a0_reg <= '{s_omega_x, s_omega_y, s_omega_z, s_lin_x, s_lin_y, s_lin_z,
                        s_angle};
        end
    end

    // Chain of CORDIC cells; link k feeds cell k.
    logic                 cv [NC+1];
    logic signed [CW-1:0] cx [NC+1];
    logic signed [CW-1:0] cy [NC+1];
    logic signed [CW-1:0] cz [NC+1];
    logic                 cf [NC+1];
    tet_pkg::axis_t       ca [NC+1];
    assign cv[0] = v0_reg;
    assign cx[0] = tet_pkg::GAIN_Q30;
    assign cy[0] = '0;
    assign cz[0] = z0_reg;
    assign cf[0] = f0_reg;
    assign ca[0] = a0_reg;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        tet_cordic_cell #(.STEP(k)) u_cell (
            .aclk, .aresetn, .en,
            .vld_in(cv[k]), .x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]),
            .flip_in(cf[k]), .ax_in(ca[k]),
            .vld_out(cv[k+1]), .x_out(cx[k+1]), .y_out(cy[k+1]), .z_out(cz[k+1]),
            .flip_out(cf[k+1]), .ax_out(ca[k+1])
        );
    end

    // Matrix tail; its last stage is the output register.
    logic signed [17:0] r [9];
    logic signed [23:0] p [3];
    tet_post u_post (
        .aclk, .aresetn, .en,
        .vld_in(cv[NC]), .x_in(cx[NC]), .y_in(cy[NC]), .flip_in(cf[NC]),
        .ax_in(ca[NC]),
        .vld_out(m_valid), .r_out(r), .p_out(p)
    );
    assign m_r00 = r[0]; assign m_r01 = r[1]; assign m_r02 = r[2];
    assign m_r10 = r[3]; assign m_r11 = r[4]; assign m_r12 = r[5];
    assign m_r20 = r[6]; assign m_r21 = r[7]; assign m_r22 = r[8];
    assign m_p_x = p[0]; assign m_p_y = p[1]; assign m_p_z = p[2];
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ============================================================================
// tb: screw-axis exponential transform testbench
// Streams axis/angle transfers through the block with random idling on both
// sides, predicts each rotation/translation with an in-bench fixed-point
// model (CORDIC sine/cosine plus Rodrigues terms) and checks results in order.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tb;
    localparam int STEPS = tet_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY = 1 + STEPS + 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic signed [17:0] r [9];
        logic signed [23:0] p [3];
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [17:0] s_omega_x = '0, s_omega_y = '0, s_omega_z = '0;
    logic signed [19:0] s_lin_x = '0, s_lin_y = '0, s_lin_z = '0;
    logic signed [18:0] s_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [17:0] m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22;
    logic signed [23:0] m_p_x, m_p_y, m_p_z;

    twist_exponential_transform_top dut (.*);

    // Free-running clock, 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    tet_pkg::axis_t pending_axes[$];   // items waiting for the driver
    pose_t expected_poses[$]; // predicted results, oldest first
    int    failures = 0;
    bit    stimulus_done = 0;
    bit    quiet_phase = 0;     // last part of the run: no idling
    int    hold_off_cycles = 0; // requested long receiver stall
    int    idle_cycles = 0;
    bit    accepted_last = 0;   // input transfer at the last rising edge

    // ---------------- prediction ----------------
    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -(64'sd1 <<< (w - 1));
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    // CORDIC rotation mode at Q30 with quadrant folding beyond +-pi/2.
    function automatic void sin_cos(longint theta, output longint s16, output longint c16);
        longint z, x, y, nx, step_atan;
        bit flip;
        z = theta * 16384;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            step_atan = longint'(tet_pkg::atan_q30(i));
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= step_atan;
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += step_atan;
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s16 = round_shift(y, 14);
        c16 = round_shift(x, 14);
    endfunction

    function automatic pose_t screw_exp(tet_pkg::axis_t ax);
        pose_t  res;
        longint w[3], v[3], sk[3][3], sk2[3][3], u[3], u2[3];
        longint th, s16, c16, a, b, acc;
        w = '{ax.wx, ax.wy, ax.wz};
        v = '{ax.vx, ax.vy, ax.vz};
        th = ax.th;
        sk = '{'{0, -w[2], w[1]}, '{w[2], 0, -w[0]}, '{-w[1], w[0], 0}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += sk[i][k] * sk[k][j];
                sk2[i][j] = acc;
            end
        sin_cos(th, s16, c16);
        a = 65536 - c16;
        b = th - s16;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = (i == j) ? (64'sd1 <<< 48) : 0;
                acc += s16 * sk[i][j] * 65536 + a * sk2[i][j];
                res.r[i * 3 + j] = 18'(clamp(round_shift(acc, 32), 18));
            end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += sk[i][k] * v[k];
            u[i] = acc;
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += sk[i][k] * u[k];
            u2[i] = round_shift(acc, 16);
        end
        for (int i = 0; i < 3; i++) begin
            acc = th * v[i] * 65536 + a * u[i] + b * u2[i];
            res.p[i] = 24'(clamp(round_shift(acc, 32), 24));
        end
        return res;
    endfunction

    // ---------------- stimulus ----------------
    function automatic tet_pkg::axis_t random_axis();
        tet_pkg::axis_t ax;
        int    mode;
        mode = $urandom_range(0, 9);
        ax.wx = 18'($urandom);
        ax.wy = 18'($urandom);
        ax.wz = 18'($urandom);
        ax.vx = 20'($urandom);
        ax.vy = 20'($urandom);
        ax.vz = 20'($urandom);
        ax.th = 19'($urandom);
        if (mode < 4) begin
            // near unit axis, components within +-1.0; the linear part stays fully random
            ax.wx = 18'($signed($urandom_range(0, 131072)) - 65536);
            ax.wy = 18'($signed($urandom_range(0, 131072)) - 65536);
            ax.wz = 18'($signed($urandom_range(0, 131072)) - 65536);
        end else if (mode == 4) begin
            ax.wx = '0;  // prismatic joint
            ax.wy = '0;
            ax.wz = '0;
        end else if (mode == 5) begin
            // angles around the +-pi/2 fold
            ax.th = 19'($signed($urandom_range(0, 400)) - 200
                        + ($urandom_range(0, 1) ? 102944 : -102944));
        end
        return ax;
    endfunction

    function automatic tet_pkg::axis_t make_axis(int wx, int wy, int wz, int vx, int vy,
                                                 int vz, int th);
        tet_pkg::axis_t ax;
        ax.wx = 18'(wx);
        ax.wy = 18'(wy);
        ax.wz = 18'(wz);
        ax.vx = 20'(vx);
        ax.vy = 20'(vy);
        ax.vz = 20'(vz);
        ax.th = 19'(th);
        return ax;
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: zero, unit axes, prismatic, extremes, pi/2 boundaries.
        pending_axes.push_back(make_axis(0, 0, 0, 0, 0, 0, 0));
        pending_axes.push_back(make_axis(65536, 0, 0, 65536, 0, 0, 102944));
        pending_axes.push_back(make_axis(0, 65536, 0, 0, 65536, 0, -102944));
        pending_axes.push_back(make_axis(0, 0, 65536, 0, 0, 65536, 205887));
        pending_axes.push_back(make_axis(0, 0, 0, 524287, -524288, 65536, 262143));
        pending_axes.push_back(make_axis(0, 0, 0, -524288, 524287, -1, -262144));
        pending_axes.push_back(make_axis(131071, 131071, 131071,
                                         524287, 524287, 524287, 262143));
        pending_axes.push_back(make_axis(-131072, -131072, -131072,
                                         -524288, -524288, -524288, -262144));
        pending_axes.push_back(make_axis(131071, -131072, 131071,
                                         -524288, 524287, -524288, 262143));
        pending_axes.push_back(make_axis(-131072, 131071, -131072,
                                         524287, -524288, 524287, -262144));
        pending_axes.push_back(make_axis(37837, 37837, 37837, 1000, -2000, 3000, 102943));
        pending_axes.push_back(make_axis(37837, -37837, 37837, 1000, 2000, -3000, 102945));
        pending_axes.push_back(make_axis(-46341, 46341, 0, 65536, 0, 0, -102945));
        pending_axes.push_back(make_axis(100000, 20000, -90000, 300000, -1, 1, 1));
        pending_axes.push_back(make_axis(1, -1, 1, -1, 1, -1, -1));
        // Long receiver stall while the sender keeps offering.
        wait (pending_axes.size() == 0);
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++) pending_axes.push_back(random_axis());
        // Sender pause until the pipeline has drained.
        wait (pending_axes.size() == 0 && hold_off_cycles == 0);
        wait (expected_poses.size() == 0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 150) begin
                wait (pending_axes.size() == 0);
                quiet_phase = 1;
            end
            pending_axes.push_back(random_axis());
        end
        wait (pending_axes.size() == 0);
        stimulus_done = 1;
    end

    // ---------------- driver ----------------
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            // transfer happened at the previous rising edge
        end
        if (!s_valid || accepted_last) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_axes.size() > 0 && aresetn) begin
                if (!quiet_phase && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 9) - 1;
                    s_valid <= 1'b0;
                end else begin
                    tet_pkg::axis_t ax;
                    ax = pending_axes.pop_front();
                    s_omega_x <= ax.wx;
                    s_omega_y <= ax.wy;
                    s_omega_z <= ax.wz;
                    s_lin_x <= ax.vx;
                    s_lin_y <= ax.vy;
                    s_lin_z <= ax.vz;
                    s_angle <= ax.th;
                    s_valid <= 1'b1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness: bursts of stall, plus the one long hold-off.
    int recv_gap = 0;
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 12) == 0) begin
            recv_gap <= $urandom_range(1, 9) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        pose_t got, want;
        accepted_last = 0;
        if (aresetn && s_valid && s_ready) begin
            tet_pkg::axis_t ax;
            ax = '{s_omega_x, s_omega_y, s_omega_z, s_lin_x, s_lin_y, s_lin_z, s_angle};
            expected_poses.push_back(screw_exp(ax));
            accepted_last = 1;
        end
        if (aresetn && m_valid && m_ready) begin
            got.r = '{m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22};
            got.p = '{m_p_x, m_p_y, m_p_z};
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected result transfer r00=%0d", $realtime, m_r00);
                failures++;
            end else begin
                want = expected_poses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.r[i] !== want.r[i]) begin
                        $display("%0t: r%0d%0d expected %0d actual %0d", $realtime,
                                 i / 3, i % 3, want.r[i], got.r[i]);
                        failures++;
                    end
                for (int i = 0; i < 3; i++)
                    if (got.p[i] !== want.p[i]) begin
                        $display("%0t: p[%0d] expected %0d actual %0d", $realtime,
                                 i, want.p[i], got.p[i]);
                        failures++;
                    end
            end
        end
    end

    // ---------------- watchdog and end of run ----------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off_cycles > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done);
        wait (expected_poses.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (failures == 0 && expected_poses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
